>>> rtl/core/bdist_pkg.sv
// Shared types, constants and helper functions for the Bhattacharyya distance pipeline.
// No dependencies; bdist_prep, bdist_iter_stage, bdist_final and the top level import it.
`default_nettype none
package bdist_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LG_STEPS      = 30;   // fraction bits of each base-2 log
	localparam int QBITS         = 41;   // quotient bits of the mean term
	localparam int ITER_STAGES   = 41;   // max(LG_STEPS, QBITS)
	localparam int LW            = 40;   // log sum, signed Q30
	localparam int PW            = 68;   // log sum times ln2

	localparam logic [26:0]          LN2_Q26   = 27'd46516320;
	localparam logic signed [LW-1:0] ONE_Q30   = 40'sd1073741824;
	localparam logic signed [LW-1:0] TWO_Q30   = 40'sd2147483648;
	localparam logic [QBITS-1:0]     MEAN_CLAMP = 41'h100_0000_0000;

	typedef struct packed {
		logic        ia;
		logic        ib;
		logic [31:0] mx;
		logic [31:0] msa;
		logic [31:0] msb;
		logic [36:0] rx;
		logic [34:0] rsa;
		logic [34:0] rsb;
		logic [65:0] rem;
		logic [40:0] nb;
		logic [40:0] q;
		logic [64:0] s;
		logic        mean_ok;
		logic        clamp;
	} iter_t;

	function automatic logic [6:0] lz66(input logic [65:0] x);
		logic [6:0] lz;
		lz = 7'd0;
		for (int i = 0; i < 66; i++) begin
			if (x[i]) lz = 7'(65 - i);
		end
		return lz;
	endfunction

	function automatic logic [5:0] lz32(input logic [31:0] x);
		logic [5:0] lz;
		lz = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) lz = 6'(31 - i);
		end
		return lz;
	endfunction

	// one squaring step of the log: {bit, next mantissa}
	function automatic logic [32:0] sq_step(input logic [31:0] m);
		logic [63:0] t;
		t = m * m;
		if (t[63]) return {1'b1, t[63:32]};
		return {1'b0, t[62:31]};
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/bdist_if.sv
// Channel interfaces: Gaussian pair requests in, distance results out.
// No dependencies.
`default_nettype none
interface bdist_pair_if;
	logic        valid;
	logic        ready;
	logic [31:0] mean_a;
	logic [31:0] sigma_a;
	logic [31:0] mean_b;
	logic [31:0] sigma_b;
	modport source (output valid, mean_a, sigma_a, mean_b, sigma_b, input ready);
	modport sink (input valid, mean_a, sigma_a, mean_b, sigma_b, output ready);
endinterface

interface bdist_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] distance;
	logic        saturated;
	modport source (output valid, distance, saturated, input ready);
	modport sink (input valid, distance, saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bdist_prep.sv
// Front stages: squares, log argument selection, leading-zero search and normalisation.
// Depends on bdist_pkg.
`default_nettype none
module bdist_prep #(
	parameter int FRAC_BITS = bdist_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic [15:0]         thr,
	input  wire logic                in_valid,
	input  wire logic [31:0]         mean_a,
	input  wire logic [31:0]         sigma_a,
	input  wire logic [31:0]         mean_b,
	input  wire logic [31:0]         sigma_b,
	output      logic                out_valid,
	output      bdist_pkg::iter_t    out_data
);
	import bdist_pkg::*;

	localparam int NW = 62 + FRAC_BITS;
	localparam int CW = (NW > 106) ? NW : 106;

	// stage 1
	logic        v_s1, ia_s1, ib_s1;
	logic [63:0] qa_s1, qb_s1;
	logic [31:0] ad_s1, sa_s1, sb_s1;
	logic signed [32:0] d;

	assign d = $signed({mean_a[31], mean_a}) - $signed({mean_b[31], mean_b});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qa_s1 <= sigma_a * sigma_a;
			qb_s1 <= sigma_b * sigma_b;
			ad_s1 <= d[32] ? 32'(-d) : d[31:0];
			sa_s1 <= sigma_a;
			sb_s1 <= sigma_b;
			ia_s1 <= sigma_a > {16'd0, thr};
			ib_s1 <= sigma_b > {16'd0, thr};
		end
	end

	// stage 2
	logic        v_s2, ia_s2, ib_s2, mean_ok_s2;
	logic [65:0] x_s2;
	logic [64:0] s_s2;
	logic [63:0] d2_s2;
	logic [31:0] sa_s2, sb_s2;
	logic [5:0]  lzsa_s2, lzsb_s2;
	logic [64:0] s_c;
	logic [65:0] x_c;
	logic [64:0] thr_sh;

	assign s_c    = {1'b0, qa_s1} + {1'b0, qb_s1};
	assign thr_sh = {49'd0, thr} << FRAC_BITS;

	always_comb begin
		if (ia_s1 && ib_s1)  x_c = {1'b0, s_c};
		else if (ia_s1)      x_c = {1'b0, qa_s1, 1'b0} + {2'b0, qb_s1};
		else if (ib_s1)      x_c = {2'b0, qa_s1} + {1'b0, qb_s1, 1'b0};
		else                 x_c = 66'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2       <= x_c;
			s_s2       <= s_c;
			d2_s2      <= ad_s1 * ad_s1;
			mean_ok_s2 <= s_c > thr_sh;
			sa_s2      <= sa_s1;
			sb_s2      <= sb_s1;
			lzsa_s2    <= lz32(sa_s1);
			lzsb_s2    <= lz32(sb_s1);
			ia_s2      <= ia_s1;
			ib_s2      <= ib_s1;
		end
	end

	// stage 3
	logic        v_s3, ia_s3, ib_s3, mean_ok_s3;
	logic [65:0] x_s3;
	logic [6:0]  lzx_s3;
	logic [64:0] s_s3;
	logic [63:0] d2_s3;
	logic [31:0] msa_s3, msb_s3;
	logic [5:0]  lzsa_s3, lzsb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3       <= x_s2;
			lzx_s3     <= lz66(x_s2);
			s_s3       <= s_s2;
			d2_s3      <= d2_s2;
			msa_s3     <= sa_s2 << lzsa_s2;
			msb_s3     <= sb_s2 << lzsb_s2;
			lzsa_s3    <= lzsa_s2;
			lzsb_s3    <= lzsb_s2;
			mean_ok_s3 <= mean_ok_s2;
			ia_s3      <= ia_s2;
			ib_s3      <= ib_s2;
		end
	end

	// stage 4
	logic [65:0]   x_norm;
	logic [NW-1:0] num;
	logic [6:0]    px;
	logic [5:0]    psa, psb;
	iter_t         nxt;
	logic          v_s4;
	iter_t         d_s4;

	assign x_norm = x_s3 << lzx_s3;
	assign num    = {d2_s3, {(FRAC_BITS - 2){1'b0}}};
	assign px     = 7'd65 - lzx_s3;
	assign psa    = 6'd31 - lzsa_s3;
	assign psb    = 6'd31 - lzsb_s3;

	always_comb begin
		nxt.ia      = ia_s3;
		nxt.ib      = ib_s3;
		nxt.mx      = x_norm[65:34];
		nxt.msa     = msa_s3;
		nxt.msb     = msb_s3;
		nxt.rx      = {px, 30'd0};
		nxt.rsa     = {psa[4:0], 30'd0};
		nxt.rsb     = {psb[4:0], 30'd0};
		nxt.rem     = {{(66 - (NW - QBITS)){1'b0}}, num[NW-1:QBITS]};
		nxt.nb      = num[QBITS-1:0];
		nxt.q       = '0;
		nxt.s       = s_s3;
		nxt.mean_ok = mean_ok_s3;
		// quotient of 2^41 or more is clamped anyway
		nxt.clamp   = {{(CW - NW){1'b0}}, num} >= {{(CW - 106){1'b0}}, s_s3, 41'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) d_s4 <= nxt;
	end

	assign out_valid = v_s4;
	assign out_data  = d_s4;

endmodule
`default_nettype wire

>>> rtl/core/bdist_iter_stage.sv
// One iteration stage: one quotient bit, plus a squaring step of each of the three logs in the first LG_STEPS stages.
// Depends on bdist_pkg.
`default_nettype none
module bdist_iter_stage #(
	parameter int K = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire bdist_pkg::iter_t in_data,
	output      logic             out_valid,
	output      bdist_pkg::iter_t out_data
);
	import bdist_pkg::*;

	iter_t       nxt;
	logic        v_q;
	iter_t       d_q;
	logic [65:0] rem2;
	logic        qbit;

	assign rem2 = {in_data.rem[64:0], in_data.nb[QBITS-1]};
	assign qbit = rem2 >= {1'b0, in_data.s};

	generate
		if (K < LG_STEPS) begin : g_lg
			localparam int BI = LG_STEPS - 1 - K;
			logic [32:0] tx, ta, tb;
			assign tx = sq_step(in_data.mx);
			assign ta = sq_step(in_data.msa);
			assign tb = sq_step(in_data.msb);
			always_comb begin
				nxt         = in_data;
				nxt.mx      = tx[31:0];
				nxt.msa     = ta[31:0];
				nxt.msb     = tb[31:0];
				nxt.rx[BI]  = tx[32];
				nxt.rsa[BI] = ta[32];
				nxt.rsb[BI] = tb[32];
				nxt.rem     = qbit ? rem2 - {1'b0, in_data.s} : rem2;
				nxt.nb      = {in_data.nb[QBITS-2:0], 1'b0};
				nxt.q       = {in_data.q[QBITS-2:0], qbit};
			end
		end else begin : g_div
			always_comb begin
				nxt     = in_data;
				nxt.rem = qbit ? rem2 - {1'b0, in_data.s} : rem2;
				nxt.nb  = {in_data.nb[QBITS-2:0], 1'b0};
				nxt.q   = {in_data.q[QBITS-2:0], qbit};
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) d_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

endmodule
`default_nettype wire

>>> rtl/core/bdist_final.sv
// Back stages: log sum, scaling by ln2, rounding, mean term clamp, sum and saturation.
// Depends on bdist_pkg. The last stage is the output register.
`default_nettype none
module bdist_final #(
	parameter int FRAC_BITS = bdist_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire bdist_pkg::iter_t in_data,
	output      logic             out_valid,
	output      logic [31:0]      distance,
	output      logic             saturated
);
	import bdist_pkg::*;

	localparam int RSH = 58 - FRAC_BITS;

	// stage 1: log sum in Q30
	logic signed [LW-1:0] rx, rsa2, rsb2, l_c;
	logic [QBITS-1:0]     meant_c;
	logic                 v_s1;
	logic signed [LW-1:0] l_s1;
	logic [QBITS-1:0]     meant_s1;

	assign rx   = $signed({3'd0, in_data.rx});
	assign rsa2 = $signed({4'd0, in_data.rsa, 1'b0});
	assign rsb2 = $signed({4'd0, in_data.rsb, 1'b0});

	always_comb begin
		if (in_data.ia && in_data.ib) l_c = (rx <<< 1) - rsa2 - rsb2 - TWO_Q30;
		else if (in_data.ia)          l_c = rx - rsa2 - TWO_Q30;
		else if (in_data.ib)          l_c = rx - rsb2 - TWO_Q30;
		else                          l_c = -ONE_Q30;
		if (!in_data.mean_ok)                            meant_c = '0;
		else if (in_data.clamp || in_data.q > MEAN_CLAMP) meant_c = MEAN_CLAMP;
		else                                             meant_c = in_data.q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s1     <= l_c;
			meant_s1 <= meant_c;
		end
	end

	// stage 2: times ln2
	logic                 v_s2;
	logic signed [PW-1:0] prod_s2;
	logic [QBITS-1:0]     meant_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2  <= PW'(l_s1 * $signed({1'b0, LN2_Q26}));
			meant_s2 <= meant_s1;
		end
	end

	// stage 3: round to nearest, add, saturate
	logic signed [PW-1:0] logt;
	logic signed [PW:0]   total;
	logic                 v_s3;
	logic [31:0]          dist_s3;
	logic                 sat_s3;

	// signed throughout so the shift floors negative sums
	assign logt  = (prod_s2 + $signed(PW'(1) << (RSH - 1))) >>> RSH;
	assign total = {logt[PW-1], logt} + $signed({{(PW + 1 - QBITS){1'b0}}, meant_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (total > $signed((PW + 1)'(32'h7fff_ffff))) begin
				dist_s3 <= 32'h7fff_ffff;
				sat_s3  <= 1'b1;
			end else if (total < -$signed((PW + 1)'(33'h0_8000_0000))) begin
				dist_s3 <= 32'h8000_0000;
				sat_s3  <= 1'b1;
			end else begin
				dist_s3 <= total[31:0];
				sat_s3  <= 1'b0;
			end
		end
	end

	assign out_valid = v_s3;
	assign distance  = dist_s3;
	assign saturated = sat_s3;

endmodule
`default_nettype wire

>>> rtl/core/bhattacharyya_distance_1d_top.sv
// Pipeline: 4 front, 41 iteration and 3 back stages between an accepted request and its result.
// Throughput: one request per cycle while the output is not stalled; the 41-stage quotient chain with the log steps
// folded into its first 30 stages sets the depth.
// The whole pipe advances unless a held result is not taken.
// Reset (arst_n, asynchronous): all valid bits and the threshold register clear.
// Top level; depends on bdist_pkg, bdist_if, bdist_prep, bdist_iter_stage, bdist_final.
`default_nettype none
module bhattacharyya_distance_1d_top #(
	parameter int FRAC_BITS = bdist_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	bdist_pair_if.sink       pair,
	bdist_result_if.source   result
);
	import bdist_pkg::*;

	logic [15:0] thr_q;
	logic        adv;
	logic        res_valid;
	logic        v   [ITER_STAGES+1];
	iter_t       st  [ITER_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign adv        = !res_valid || result.ready;
	assign pair.ready = adv;

	bdist_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.thr       (thr_q),
		.in_valid  (pair.valid),
		.mean_a    (pair.mean_a),
		.sigma_a   (pair.sigma_a),
		.mean_b    (pair.mean_b),
		.sigma_b   (pair.sigma_b),
		.out_valid (v[0]),
		.out_data  (st[0])
	);

	for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
		bdist_iter_stage #(.K(k)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (v[k]),
			.in_data   (st[k]),
			.out_valid (v[k+1]),
			.out_data  (st[k+1])
		);
	end

	bdist_final #(.FRAC_BITS(FRAC_BITS)) u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v[ITER_STAGES]),
		.in_data   (st[ITER_STAGES]),
		.out_valid (res_valid),
		.distance  (result.distance),
		.saturated (result.saturated)
	);

	assign result.valid = res_valid;

endmodule
`default_nettype wire

>>> rtl/core/bdist_checker.sv
// Port-level assertions for the distance block, bound to the top level.
// Depends on bhattacharyya_distance_1d_top.
`default_nettype none
module bdist_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] distance,
	input wire logic        saturated
);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(saturated))
		else $error("stalled result changed");

	// requests are taken whenever the output stage is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("request refused with free output stage");

	// stalled output blocks the input side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while pipe stalled");

	// only the upper clip is reachable
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> distance == 32'h7fff_ffff)
		else $error("saturated result not at upper bound");

endmodule

bind bhattacharyya_distance_1d_top bdist_checker u_bdist_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pair.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.distance  (result.distance),
	.saturated (result.saturated)
);
`default_nettype wire
